// ----- hdl/rpxe_pkg.sv -----
// shared constants, types and elaboration-time matrix build for the recursive prefix-xor encoder
package rpxe_pkg;

  localparam int unsigned WordWidth   = 64;
  localparam int unsigned WEIGHT_WIDTH = 23;
  localparam int unsigned PopWidth    = $clog2(WordWidth + 1);
  localparam int unsigned InTdataWidth  = 2 * WordWidth;
  localparam int unsigned OutFieldWidth = 2 * WordWidth + WEIGHT_WIDTH;
  localparam int unsigned OutTdataWidth = ((OutFieldWidth + 7) / 8) * 8;

  localparam logic [WordWidth-1:0] GenPoly = 64'hF4845518B9582A1F;
  localparam logic [WordWidth-1:0] TopBit  = 64'h8000000000000000;
  localparam logic [WEIGHT_WIDTH-1:0] WeightMax = '1;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [WEIGHT_WIDTH-1:0] weight_t;
  typedef word_t mat_t [WordWidth];

  typedef struct packed {
    word_t   coded;
    word_t   next_state;
    weight_t weight;
  } step_res_t;

  function automatic word_t clmul_low(input word_t a, input word_t b);
    word_t r;
    r = '0;
    for (int i = 0; i < WordWidth; i++) begin
      if (b[i]) begin
        r = r ^ (a << i);
      end
    end
    return r;
  endfunction

  function automatic word_t poly_inverse();
    word_t inv;
    word_t prod;
    inv = word_t'(1);
    for (int i = 1; i < WordWidth; i++) begin
      prod = clmul_low(GenPoly, inv);
      if (prod[i]) begin
        inv[i] = 1'b1;
      end
    end
    return inv;
  endfunction

  function automatic word_t code_high(input word_t msg);
    word_t hi;
    word_t part;
    hi = '0;
    for (int i = 0; i < WordWidth; i++) begin
      if (msg[i]) begin
        part = (i == 0) ? '0 : (GenPoly >> (WordWidth - i));
        hi = hi ^ (part | TopBit);
      end
    end
    return hi;
  endfunction

  function automatic mat_t build_matrix();
    mat_t  m;
    word_t inv;
    inv = poly_inverse();
    for (int c = 0; c < WordWidth; c++) begin
      m[c] = code_high(inv << c);
    end
    return m;
  endfunction

  localparam mat_t StepMatrix = build_matrix();

endpackage

// ----- hdl/recursive_prefix_xor_encoder_step.sv -----
// top level of the recursive prefix-xor encoder: input register, step logic, result register
//
//  channel | dir | tdata (low bit up)                     | tuser     | tlast
//  s_*     | in  | start_state[63:0], data_word[127:64]   | start_lap | last_word
//  m_*     | out | coded_word, next_state, lap_weight, pad| -         | lap_done
//
//  one word per cycle while m is not stalled; a word reaches m via input and result registers
//  the chain state and weight loop closes through the combinational rpxe_step
//  rst clears both valid flags, the chain state and the weight
//  a stalled m side holds its word; s_tready stays high while the input stage can move
module recursive_prefix_xor_encoder_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rpxe_pkg::InTdataWidth-1:0]    s_tdata,  // start_state, data_word
  input  logic                                 s_tuser,  // start_lap
  input  logic                                 s_tlast,  // last_word
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rpxe_pkg::OutTdataWidth-1:0]   m_tdata,  // coded_word, next_state, lap_weight
  output logic                                 m_tlast   // lap_done
);

  logic              in_valid;
  logic              in_start;
  logic              in_last;
  rpxe_pkg::word_t   in_start_state;
  rpxe_pkg::word_t   in_data;

  logic              out_valid;
  logic              out_last;
  rpxe_pkg::step_res_t out_res;

  rpxe_pkg::word_t   chain_state;
  rpxe_pkg::weight_t weight_total;

  rpxe_pkg::word_t   step_state;
  rpxe_pkg::weight_t step_weight;
  rpxe_pkg::step_res_t step_res;
  logic              advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign step_state  = in_start ? in_start_state : chain_state;
  assign step_weight = in_start ? '0 : weight_total;

  rpxe_step u_step (
    .state     (step_state),
    .data_word (in_data),
    .weight    (step_weight),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start       <= s_tuser;
      in_last        <= s_tlast;
      in_start_state <= s_tdata[rpxe_pkg::WordWidth-1:0];
      in_data        <= s_tdata[rpxe_pkg::InTdataWidth-1:rpxe_pkg::WordWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      chain_state  <= '0;
      weight_total <= '0;
    end else begin
      if (advance) begin
        out_valid    <= 1'b1;
        chain_state  <= step_res.next_state;
        weight_total <= step_res.weight;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res  <= step_res;
      out_last <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(rpxe_pkg::OutTdataWidth - rpxe_pkg::OutFieldWidth){1'b0}},
                     out_res.weight, out_res.next_state, out_res.coded};

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after step");

  a_state_matches_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chain_state == out_res.next_state))
    else $error("chain state differs from last delivered next_state");

  a_weight_matches_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight_total == out_res.weight))
    else $error("weight total differs from last delivered weight");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(chain_state) && $stable(weight_total))
    else $error("chain state changed without a step");

endmodule

// ----- hdl/rpxe_step.sv -----
// one encoder step: prefix xor, state matrix, popcount and saturating weight add
module rpxe_step (
  input  rpxe_pkg::word_t     state,
  input  rpxe_pkg::word_t     data_word,
  input  rpxe_pkg::weight_t   weight,
  output rpxe_pkg::step_res_t res
);

  rpxe_pkg::word_t coded;
  rpxe_pkg::word_t nxt;
  logic [rpxe_pkg::PopWidth-1:0] pop;
  logic [rpxe_pkg::WEIGHT_WIDTH:0] sum;

  always_comb begin
    coded = state ^ data_word;
    coded = coded ^ (coded << 1);
    coded = coded ^ (coded << 2);
    coded = coded ^ (coded << 4);
    coded = coded ^ (coded << 8);
    coded = coded ^ (coded << 16);
    coded = coded ^ (coded << 32);
  end

  // fixed gf(2) matrix, reduces to per-bit xor trees
  always_comb begin
    nxt = '0;
    for (int i = 0; i < rpxe_pkg::WordWidth; i++) begin
      nxt = nxt ^ (rpxe_pkg::StepMatrix[i] & {rpxe_pkg::WordWidth{coded[i]}});
    end
  end

  // balanced adder tree left to synthesis
  always_comb begin
    pop = rpxe_pkg::PopWidth'($countones(coded));
  end

  always_comb begin
    sum = {1'b0, weight} + (rpxe_pkg::WEIGHT_WIDTH + 1)'(pop);
    res.coded      = coded;
    res.next_state = nxt;
    res.weight     = sum[rpxe_pkg::WEIGHT_WIDTH] ? rpxe_pkg::WeightMax
                                                 : sum[rpxe_pkg::WEIGHT_WIDTH-1:0];
  end

endmodule
